>>> hw/rtl/csr_pkg.sv
// Shared types and constants for the conic scan-line root finder.
// No dependencies; imported by every module in hw/rtl.
package csr_pkg;

  localparam int COEF_W = 32;  // coefficient width, signed fixed point
  localparam int RES_W  = 32;  // root width on the result stream
  localparam int EXT_W  = 13;  // cross_extent width
  localparam int IDX_W  = 3;   // config register index width

  localparam logic [EXT_W-1:0] EXTENT_RST = EXT_W'(4096);

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_XX,
    REG_COEF_XY,
    REG_COEF_YY,
    REG_COEF_X,
    REG_COEF_Y,
    REG_COEF_CONST,
    REG_SOLVE_FOR_Y,
    REG_CROSS_EXTENT
  } csr_reg_t;

  // per-stage control travelling alongside the payload
  typedef struct packed {
    logic vld;
    logic ok;
  } csr_ctl_t;

  typedef struct packed {
    logic [COEF_W-1:0] xx;
    logic [COEF_W-1:0] xy;
    logic [COEF_W-1:0] yy;
    logic [COEF_W-1:0] x;
    logic [COEF_W-1:0] y;
    logic [COEF_W-1:0] cst;
    logic              solve_y;
    logic [EXT_W-1:0]  extent;
  } csr_cfg_t;

  // divisor of the quadratic: coefficient of the solved axis squared
  function automatic logic signed [COEF_W-1:0] csr_divisor(input csr_cfg_t cfg);
    csr_divisor = cfg.solve_y ? $signed(cfg.yy) : $signed(cfg.xx);
  endfunction

endpackage

>>> hw/rtl/csr_front.sv
// Front pipeline: forms b, G and the discriminant b*b - d*G from the scan coordinate.
// Depends on csr_pkg; wide products are split into partial products over stages.
module csr_front import csr_pkg::*; #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [COORD_WIDTH-1:0]        coord,
  input  csr_cfg_t                      cfg,
  output csr_ctl_t                      ctl_o,
  output logic signed [2*COORD_WIDTH+66:0] delta_o,
  output logic signed [COORD_WIDTH+32:0]   b_o
);

  localparam int SW = COORD_WIDTH;
  localparam int BW = 33 + SW;        // b and h
  localparam int PW = COEF_W + SW + 1; // coefficient times coordinate
  localparam int BM = 32 + SW;        // magnitude of b
  localparam int BL = BM / 2;
  localparam int BH = BM - BL;
  localparam int GW = 34 + 2*SW;      // G
  localparam int GL = GW / 2;
  localparam int GH = GW - GL;
  localparam int DW = 67 + 2*SW;      // discriminant

  logic signed [COEF_W-1:0] cq, cl, cm, cd, cb, cf;

  assign cq = cfg.solve_y ? $signed(cfg.xx) : $signed(cfg.yy);
  assign cl = cfg.solve_y ? $signed(cfg.x)  : $signed(cfg.y);
  assign cm = cfg.solve_y ? $signed(cfg.y)  : $signed(cfg.x);
  assign cd = csr_divisor(cfg);
  assign cb = $signed(cfg.xy);
  assign cf = $signed(cfg.cst);

  csr_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  logic [SW-1:0]            s1_r, s2_r, s3_r;
  logic signed [PW-1:0]     bs2_r, qs2_r;
  logic signed [BW-1:0]     b3_r, b4_r, b5_r, b6_r, b7_r, h3_r;
  logic [BM-1:0]            bm4_r;
  logic signed [GW-1:0]     sh4_r, g5_r;
  logic [2*BL-1:0]          pll5_r;
  logic [BL+BH-1:0]         plh5_r;
  logic [2*BH-1:0]          phh5_r;
  logic [2*BM-1:0]          bb6_r;
  logic signed [COEF_W+GL:0]   pdl6_r;
  logic signed [COEF_W+GH-1:0] pdh6_r;
  logic signed [DW-1:0]     delta7_r;

  logic signed [BW-1:0]     b3_nxt, h3_nxt;
  logic [BM-1:0]            bm4_nxt;
  logic [2*BM-1:0]          bb6_nxt;
  logic signed [DW-1:0]     dg7, delta7_nxt;

  always_comb begin
    b3_nxt  = BW'(bs2_r) + BW'(cm);
    h3_nxt  = BW'(qs2_r) + (BW'(cl) <<< 1);
    bm4_nxt = b3_r[BW-1] ? BM'(-b3_r) : BM'(b3_r);
    bb6_nxt = ({{(2*BM-2*BH){1'b0}}, phh5_r} << (2*BL))
            + ({{(2*BM-BL-BH){1'b0}}, plh5_r} << (BL+1))
            + {{(2*BM-2*BL){1'b0}}, pll5_r};
    dg7        = (DW'(pdh6_r) <<< GL) + DW'(pdl6_r);
    delta7_nxt = DW'($signed({1'b0, bb6_r})) - dg7;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else if (adv) begin
      ctl1_r <= '{vld: in_vld, ok: (cd != '0)};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= coord;
      s2_r     <= s1_r;
      s3_r     <= s2_r;
      bs2_r    <= cb * $signed({1'b0, s1_r});
      qs2_r    <= cq * $signed({1'b0, s1_r});
      b3_r     <= b3_nxt;
      h3_r     <= h3_nxt;
      b4_r     <= b3_r;
      bm4_r    <= bm4_nxt;
      sh4_r    <= $signed({1'b0, s3_r}) * h3_r;
      b5_r     <= b4_r;
      g5_r     <= sh4_r + GW'(cf);
      pll5_r   <= bm4_r[BL-1:0] * bm4_r[BL-1:0];
      plh5_r   <= bm4_r[BL-1:0] * bm4_r[BM-1:BL];
      phh5_r   <= bm4_r[BM-1:BL] * bm4_r[BM-1:BL];
      b6_r     <= b5_r;
      bb6_r    <= bb6_nxt;
      pdl6_r   <= cd * $signed({1'b0, g5_r[GL-1:0]});
      pdh6_r   <= cd * $signed(g5_r[GW-1:GL]);
      b7_r     <= b6_r;
      delta7_r <= delta7_nxt;
    end
  end

  assign ctl_o   = ctl7_r;
  assign delta_o = delta7_r;
  assign b_o     = b7_r;

endmodule

>>> hw/rtl/csr_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per stage.
// Depends on csr_pkg for the control struct.
module csr_sqrt_cell import csr_pkg::*; #(
  parameter int RW = 45,
  parameter int BW = 45
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  csr_ctl_t             ctl_i,
  input  logic [2*RW-1:0]      rad_i,
  input  logic [RW+2:0]        rem_i,
  input  logic [RW-1:0]        root_i,
  input  logic signed [BW-1:0] b_i,
  output csr_ctl_t             ctl_o,
  output logic [2*RW-1:0]      rad_o,
  output logic [RW+2:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic signed [BW-1:0] b_o
);

  localparam int RMW = RW + 3;

  csr_ctl_t              ctl_r;
  logic [2*RW-1:0]       rad_r;
  logic [RMW-1:0]        rem_r, rem_nxt;
  logic [RW-1:0]         root_r, root_nxt;
  logic signed [BW-1:0]  b_r;
  logic [RMW-1:0]        t, trial;
  logic                  ge;

  always_comb begin
    t        = {rem_i[RMW-3:0], rad_i[2*RW-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = (t >= trial);
    rem_nxt  = ge ? (t - trial) : t;
    root_nxt = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= {rad_i[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      b_r    <= b_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign b_o    = b_r;

endmodule

>>> hw/rtl/csr_div_cell.sv
// One cell of the divider chain: one quotient bit per stage for both roots.
// Depends on csr_pkg; lane 0 carries the plus root, lane 1 the minus root.
module csr_div_cell import csr_pkg::*; #(
  parameter int NW = 62
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [COEF_W-1:0]             dmag,
  input  csr_ctl_t                      ctl_i,
  input  logic [1:0][COEF_W+NW-1:0]     a_i,
  input  logic [1:0]                    neg_i,
  output csr_ctl_t                      ctl_o,
  output logic [1:0][COEF_W+NW-1:0]     a_o,
  output logic [1:0]                    neg_o
);

  localparam int AW = COEF_W + NW;

  csr_ctl_t                ctl_r;
  logic [1:0][AW-1:0]      a_r, a_nxt;
  logic [1:0]              neg_r;
  logic [1:0][COEF_W:0]    t, diff;
  logic [1:0]              ge;

  // a holds {partial remainder, dividend bits still to come / quotient so far}
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      t[g]     = a_i[g][AW-1:NW-1];
      diff[g]  = t[g] - {1'b0, dmag};
      ge[g]    = (t[g] >= {1'b0, dmag});
      a_nxt[g] = {(ge[g] ? diff[g][COEF_W-1:0] : t[g][COEF_W-1:0]),
                  a_i[g][NW-2:0], ge[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= a_nxt;
      neg_r <= neg_i;
    end
  end

  assign ctl_o = ctl_r;
  assign a_o   = a_r;
  assign neg_o = neg_r;

endmodule

>>> hw/rtl/csr_back.sv
// Back end: floors the signed quotients, clamps to Q16.16 and checks the extent.
// Depends on csr_pkg; holds the output register of the result stream.
module csr_back import csr_pkg::*; #(
  parameter int NW = 62,
  parameter int FB = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  csr_cfg_t                  cfg,
  input  csr_ctl_t                  ctl_i,
  input  logic [1:0][COEF_W+NW-1:0] a_i,
  input  logic [1:0]                neg_i,
  output logic                      vld_o,
  output logic                      has_o,
  output logic [RES_W-1:0]          rp_o,
  output logic [RES_W-1:0]          rm_o,
  output logic                      pin_o,
  output logic                      min_o,
  output logic                      sat_o
);

  localparam int AW = COEF_W + NW;

  csr_ctl_t               ctl1_r;
  logic [1:0][NW:0]       r1_r, r1_nxt;
  logic [1:0][NW-1:0]     qm;
  logic [1:0]             remnz, ovp, ovn, ins;
  logic [1:0][RES_W-1:0]  cl;
  logic [NW-1:0]          limit;

  logic                   vld_r, has_r, pin_r, min_r, sat_r;
  logic [RES_W-1:0]       rp_r, rm_r;

  always_comb begin
    limit = NW'({cfg.extent, {FB{1'b0}}});
    for (int g = 0; g < 2; g++) begin
      qm[g]    = a_i[g][NW-1:0];
      remnz[g] = |a_i[g][AW-1:NW];
      // toward minus infinity: -q, less one more when the division was inexact
      if (neg_i[g]) begin
        r1_nxt[g] = remnz[g] ? ~{1'b0, qm[g]} : -{1'b0, qm[g]};
      end else begin
        r1_nxt[g] = {1'b0, qm[g]};
      end
      ovp[g] = !r1_r[g][NW] && (|r1_r[g][NW-1:RES_W-1]);
      ovn[g] = r1_r[g][NW] && !(&r1_r[g][NW-1:RES_W-1]);
      if (ovp[g]) begin
        cl[g] = {1'b0, {(RES_W-1){1'b1}}};
      end else if (ovn[g]) begin
        cl[g] = {1'b1, {(RES_W-1){1'b0}}};
      end else begin
        cl[g] = r1_r[g][RES_W-1:0];
      end
      ins[g] = !r1_r[g][NW] && (r1_r[g][NW-1:0] < limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      vld_r  <= 1'b0;
    end else if (adv) begin
      ctl1_r <= ctl_i;
      vld_r  <= ctl1_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r  <= r1_nxt;
      has_r <= ctl1_r.ok;
      rp_r  <= ctl1_r.ok ? cl[0] : '0;
      rm_r  <= ctl1_r.ok ? cl[1] : '0;
      pin_r <= ctl1_r.ok && ins[0];
      min_r <= ctl1_r.ok && ins[1];
      sat_r <= ctl1_r.ok && (|ovp || |ovn);
    end
  end

  assign vld_o = vld_r;
  assign has_o = has_r;
  assign rp_o  = rp_r;
  assign rm_o  = rm_r;
  assign pin_o = pin_r;
  assign min_o = min_r;
  assign sat_o = sat_r;

endmodule

>>> hw/rtl/conic_scanline_roots_core.sv
// Conic scan-line intersection: top level with config registers and the cell chains.
// Depends on csr_pkg, csr_front, csr_sqrt_cell, csr_div_cell and csr_back.
//
// Takes one scan coordinate per clock and returns both roots of the conic along that
// line in signed Q16.16, in order, one result per coordinate. The datapath is a single
// pipeline: 7 front stages, one square-root cell per root bit (33 + COORD_WIDTH), 2
// numerator stages, one divider cell per quotient bit (34 + COORD_WIDTH + FRAC_BITS)
// and 2 back stages. The whole pipe advances while the output register is empty or
// being taken; when a result waits with out_tready low the pipe holds and in_tready
// drops. Coefficients may only be rewritten once all results in flight have been
// delivered.
module conic_scanline_roots_core import csr_pkg::*; #(
  parameter int COORD_WIDTH = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // scan_coord
  input  logic [((COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // root_plus [31:0], root_minus [63:32]
  output logic [2*RES_W-1:0]                  out_tdata,
  // has_solution, plus_inside, minus_inside, saturated
  output logic [3:0]                          out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [IDX_W-1:0]                    cfg_index,
  input  logic [COEF_W-1:0]                   cfg_data
);

  localparam int SW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int BW = 33 + SW;
  localparam int DW = 67 + 2*SW;
  localparam int RW = 33 + SW;
  localparam int XW = 34 + SW;
  localparam int NW = XW + FB;
  localparam int AW = COEF_W + NW;

  // configuration registers
  csr_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{solve_y: 1'b1, extent: EXTENT_RST, default: '0};
    end else if (cfg_valid) begin
      case (csr_reg_t'(cfg_index))
        REG_COEF_XX:      cfg_r.xx      <= cfg_data;
        REG_COEF_XY:      cfg_r.xy      <= cfg_data;
        REG_COEF_YY:      cfg_r.yy      <= cfg_data;
        REG_COEF_X:       cfg_r.x       <= cfg_data;
        REG_COEF_Y:       cfg_r.y       <= cfg_data;
        REG_COEF_CONST:   cfg_r.cst     <= cfg_data;
        REG_SOLVE_FOR_Y:  cfg_r.solve_y <= cfg_data[0];
        REG_CROSS_EXTENT: cfg_r.extent  <= cfg_data[EXT_W-1:0];
        default:          cfg_r         <= cfg_r;
      endcase
    end
  end

  logic adv;
  logic vld_out;

  assign adv       = !vld_out || out_tready;
  assign in_tready = adv;

  logic signed [COEF_W-1:0] dsel;
  logic [COEF_W-1:0]        dmag;

  assign dsel = csr_divisor(cfg_r);
  assign dmag = dsel[COEF_W-1] ? COEF_W'(-dsel) : COEF_W'(dsel);

  // front
  csr_ctl_t             f_ctl;
  logic signed [DW-1:0] f_delta;
  logic signed [BW-1:0] f_b;

  csr_front #(.COORD_WIDTH(SW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_tvalid),
    .coord   (in_tdata[SW-1:0]),
    .cfg     (cfg_r),
    .ctl_o   (f_ctl),
    .delta_o (f_delta),
    .b_o     (f_b)
  );

  // square-root chain
  csr_ctl_t                sq_ctl  [RW+1];
  logic [2*RW-1:0]         sq_rad  [RW+1];
  logic [RW+2:0]           sq_rem  [RW+1];
  logic [RW-1:0]           sq_root [RW+1];
  logic signed [BW-1:0]    sq_b    [RW+1];

  assign sq_ctl[0]  = '{vld: f_ctl.vld, ok: f_ctl.ok && !f_delta[DW-1]};
  assign sq_rad[0]  = f_delta[2*RW-1:0];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_b[0]    = f_b;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    csr_sqrt_cell #(.RW(RW), .BW(BW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (sq_ctl[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .b_i    (sq_b[i]),
      .ctl_o  (sq_ctl[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .b_o    (sq_b[i+1])
    );
  end

  // numerators -b + r and -b - r, then magnitude and quotient sign
  csr_ctl_t             p1_ctl_r, p2_ctl_r;
  logic signed [XW:0]   xp1_r, xm1_r, xp1_nxt, xm1_nxt;
  logic [1:0][AW-1:0]   a2_r, a2_nxt;
  logic [1:0]           neg2_r, neg2_nxt;
  logic [1:0][XW-1:0]   xmag;

  always_comb begin
    xp1_nxt = XW'($unsigned(sq_root[RW])) - (XW+1)'(sq_b[RW]);
    xm1_nxt = -(XW+1)'(sq_b[RW]) - XW'($unsigned(sq_root[RW]));
    xmag[0] = xp1_r[XW] ? XW'(-xp1_r) : xp1_r[XW-1:0];
    xmag[1] = xm1_r[XW] ? XW'(-xm1_r) : xm1_r[XW-1:0];
    a2_nxt[0]   = {{COEF_W{1'b0}}, xmag[0], {FB{1'b0}}};
    a2_nxt[1]   = {{COEF_W{1'b0}}, xmag[1], {FB{1'b0}}};
    neg2_nxt[0] = xp1_r[XW] ^ dsel[COEF_W-1];
    neg2_nxt[1] = xm1_r[XW] ^ dsel[COEF_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r <= '0;
      p2_ctl_r <= '0;
    end else if (adv) begin
      p1_ctl_r <= sq_ctl[RW];
      p2_ctl_r <= p1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xp1_r  <= xp1_nxt;
      xm1_r  <= xm1_nxt;
      a2_r   <= a2_nxt;
      neg2_r <= neg2_nxt;
    end
  end

  // divider chain
  csr_ctl_t            dv_ctl [NW+1];
  logic [1:0][AW-1:0]  dv_a   [NW+1];
  logic [1:0]          dv_neg [NW+1];

  assign dv_ctl[0] = p2_ctl_r;
  assign dv_a[0]   = a2_r;
  assign dv_neg[0] = neg2_r;

  for (genvar j = 0; j < NW; j++) begin : g_div
    csr_div_cell #(.NW(NW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .dmag  (dmag),
      .ctl_i (dv_ctl[j]),
      .a_i   (dv_a[j]),
      .neg_i (dv_neg[j]),
      .ctl_o (dv_ctl[j+1]),
      .a_o   (dv_a[j+1]),
      .neg_o (dv_neg[j+1])
    );
  end

  // back end and output register
  logic             has_solution, plus_inside, minus_inside, saturated;
  logic [RES_W-1:0] root_plus, root_minus;

  csr_back #(.NW(NW), .FB(FB)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cfg   (cfg_r),
    .ctl_i (dv_ctl[NW]),
    .a_i   (dv_a[NW]),
    .neg_i (dv_neg[NW]),
    .vld_o (vld_out),
    .has_o (has_solution),
    .rp_o  (root_plus),
    .rm_o  (root_minus),
    .pin_o (plus_inside),
    .min_o (minus_inside),
    .sat_o (saturated)
  );

  assign out_tvalid = vld_out;
  assign out_tdata  = {root_minus, root_plus};
  assign out_tuser  = {saturated, minus_inside, plus_inside, has_solution};

endmodule

>>> test/conic_root_checker.sv
// Scoreboard for the conic scan-line root finder: mirrors the config registers,
// predicts each result at input transfer and compares it with the result stream.
// Depends on csr_pkg for register indexes and widths.
module conic_root_checker import csr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         in_tdata,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [2*RES_W-1:0]  out_tdata,
  input  logic [3:0]          out_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]   cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic              has_solution;
    logic [RES_W-1:0]  root_plus;
    logic [RES_W-1:0]  root_minus;
    logic              plus_inside;
    logic              minus_inside;
    logic              saturated;
  } roots_t;

  logic signed [COEF_W-1:0] coef [6];
  logic                     solve_y;
  logic [EXT_W-1:0]         extent;
  roots_t                   expected_roots [$];

  localparam wide_t MAX_Q = 128'sd2147483647;
  localparam wide_t MIN_Q = -128'sd2147483648;

  assign pending = expected_roots.size();

  function automatic wide_t floor_div(wide_t n, wide_t dv);
    wide_t qt;
    qt = n / dv;
    if ((n % dv) != 0 && ((n < 0) != (dv < 0))) qt = qt - 1;
    return qt;
  endfunction

  function automatic logic [RES_W-1:0] clamp_q(wide_t v, inout logic sat);
    if (v > MAX_Q) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < MIN_Q) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic roots_t solve_line(logic [11:0] coord);
    roots_t res;
    wide_t s, q, l, m, dv, b, g, delta, rp, rm, lim;
    logic [127:0] r, cand;
    logic sat;
    res = '{default: '0};
    sat = 1'b0;
    s = $signed({116'b0, coord});
    if (solve_y) begin
      q = coef[REG_COEF_XX]; l = coef[REG_COEF_X]; m = coef[REG_COEF_Y];
      dv = coef[REG_COEF_YY];
    end else begin
      q = coef[REG_COEF_YY]; l = coef[REG_COEF_Y]; m = coef[REG_COEF_X];
      dv = coef[REG_COEF_XX];
    end
    if (dv == 0) return res;
    b = wide_t'(coef[REG_COEF_XY]) * s + m;
    g = s * (q * s + 2 * l) + wide_t'(coef[REG_COEF_CONST]);
    delta = b * b - dv * g;
    if (delta < 0) return res;
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      cand = r | (128'd1 << bit_i);
      if (cand * cand <= delta) r = cand;
    end
    rp = floor_div(((-b) + $signed(r)) <<< 16, dv);
    rm = floor_div(((-b) - $signed(r)) <<< 16, dv);
    lim = $signed({115'b0, extent}) <<< 16;
    res.has_solution = 1'b1;
    res.root_plus    = clamp_q(rp, sat);
    res.root_minus   = clamp_q(rm, sat);
    res.plus_inside  = rp >= 0 && rp < lim;
    res.minus_inside = rm >= 0 && rm < lim;
    res.saturated    = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    roots_t want;
    int     errs;
    if (!rst_n) begin
      foreach (coef[i]) coef[i] <= '0;
      solve_y    <= 1'b1;
      extent     <= EXTENT_RST;
      fail_count <= 0;
      expected_roots.delete();
    end else begin
      errs = 0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_COEF_CONST) coef[cfg_index] <= cfg_data;
        else if (cfg_index == REG_SOLVE_FOR_Y) solve_y <= cfg_data[0];
        else if (cfg_index == REG_CROSS_EXTENT) extent <= cfg_data[EXT_W-1:0];
      end
      if (in_tvalid && in_tready) expected_roots.push_back(solve_line(in_tdata[11:0]));
      if (out_tvalid && out_tready) begin
        if (expected_roots.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          want = expected_roots.pop_front();
          if (out_tuser[0] !== want.has_solution) begin
            $error("has_solution: expected %0b got %0b", want.has_solution, out_tuser[0]);
            errs++;
          end
          if (out_tdata[31:0] !== want.root_plus) begin
            $error("root_plus: expected %h got %h", want.root_plus, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[63:32] !== want.root_minus) begin
            $error("root_minus: expected %h got %h", want.root_minus, out_tdata[63:32]);
            errs++;
          end
          if (out_tuser[1] !== want.plus_inside) begin
            $error("plus_inside: expected %0b got %0b", want.plus_inside, out_tuser[1]);
            errs++;
          end
          if (out_tuser[2] !== want.minus_inside) begin
            $error("minus_inside: expected %0b got %0b", want.minus_inside, out_tuser[2]);
            errs++;
          end
          if (out_tuser[3] !== want.saturated) begin
            $error("saturated: expected %0b got %0b", want.saturated, out_tuser[3]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

>>> test/conic_scanline_roots_core_tb.sv
// Top of the conic scan-line root finder testbench: clock, reset, stimulus and verdict.
// Depends on csr_pkg, conic_scanline_roots_core and conic_root_checker.
module conic_scanline_roots_core_tb;
  import csr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int S = 65536;

  logic                clk;
  logic                rst_n;
  logic [15:0]         in_tdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [2*RES_W-1:0]  out_tdata;
  logic [3:0]          out_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [COEF_W-1:0]   cfg_data;
  int                  fail_count;
  int                  pending;

  conic_scanline_roots_core dut (.*);
  conic_root_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("conic_scanline_roots_core_tb NOT OK");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side back-pressure: bursts of ready with random stalls
  initial begin
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk);
      repeat (gap_len()) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(csr_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_conic(int a, int b, int c, int d, int e, int f, bit sy, int ext);
    write_reg(REG_COEF_XX, a);
    write_reg(REG_COEF_XY, b);
    write_reg(REG_COEF_YY, c);
    write_reg(REG_COEF_X, d);
    write_reg(REG_COEF_Y, e);
    write_reg(REG_COEF_CONST, f);
    write_reg(REG_SOLVE_FOR_Y, sy);
    write_reg(REG_CROSS_EXTENT, ext);
  endtask

  task automatic send_coord(int coord);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, 12'(coord)};
    do @(posedge clk); while (!in_tready);
    repeat (gap_len()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and let every expected result drain
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int cx, cy, rad, kind, ext;
    int chord_pts [7];
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF_XX;
    cfg_data  = '0;
    rst_n     = 1'b0;
    chord_pts = '{50, 100, 150, 49, 151, 0, 75};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero divisor everywhere
    send_coord(0);
    send_coord(4095);
    drain();

    // circle centre (100,100) radius 50: tangent, chord, miss
    set_conic(S, 0, S, -100 * S, -100 * S, (2 * 100 * 100 - 2500) * S, 1'b1, 4096);
    foreach (chord_pts[i])
      send_coord(chord_pts[i]);
    drain();

    set_conic(S, 0, S, -100 * S, -100 * S, (2 * 100 * 100 - 2500) * S, 1'b0, 1);
    send_coord(100);
    send_coord(60);
    send_coord(4095);
    drain();

    // coefficient extremes
    set_conic(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 1'b1, 4096);
    send_coord(0);
    send_coord(4095);
    send_coord(2048);
    drain();

    // unit divisor with a large linear term: the minus root overflows Q16.16
    set_conic(0, 0, 1, 0, 32'h4000_0000, 32'h8000_0000, 1'b1, 4096);
    send_coord(0);
    send_coord(4095);
    send_coord(1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      kind = $urandom_range(3);
      ext  = (phase == 0) ? 1 : (phase == 1) ? 4096 : $urandom_range(4096, 1);
      cx   = $urandom_range(180);
      cy   = $urandom_range(180);
      rad  = $urandom_range(90, 1);
      if (kind < 2)
        set_conic(S, 0, S, -cx * S, -cy * S, (cx * cx + cy * cy - rad * rad) * S,
                  $urandom_range(1), ext);
      else if (kind == 2)
        // tilted ellipse or hyperbola with small signed quadratic and linear coefficients
        set_conic($urandom_range(2 * S) - S, $urandom_range(S) - S / 2,
                  $urandom_range(2 * S) - S, $urandom_range(400 * S) - 200 * S,
                  $urandom_range(400 * S) - 200 * S, $urandom, $urandom_range(1), ext);
      else
        set_conic($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1), ext);
      repeat (48) begin
        if (kind < 3 && $urandom_range(3) != 0)
          send_coord($urandom_range(kind < 2 ? cx + rad + 2 : 400, 0));
        else
          send_coord($urandom_range(4095));
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("conic_scanline_roots_core_tb OK");
    end else begin
      $display("conic_scanline_roots_core_tb NOT OK");
    end
    $finish;
  end
endmodule
